### rtl/pfx_pkg.sv
// ============================================================================
// pfx_pkg: shared types and constants of the postfix expression evaluator
// Character codes, status codes, operator codes, state types and the
// request and response bundles between the controller and the arithmetic unit.
// ============================================================================
package pfx_pkg;

    localparam int PFX_STACK_DEPTH = 16;
    localparam int DATA_W          = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_alu_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CALC,
        S_END
    } t_ctl_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_SIGN,
        A_POW,
        A_DONE
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

### rtl/pfx_stack_mem.sv
// ============================================================================
// pfx_stack_mem: operand stack storage
// Single-port-write, single-port-read memory with a registered read.
// ============================================================================
module pfx_stack_mem
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = PFX_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]              i_wr_data,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]              o_rd_data
);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pfx_alu.sv
// ============================================================================
// pfx_alu: arithmetic unit of the evaluator
// Add, subtract and multiply in one step; restoring division one quotient
// bit per cycle; power by square and multiply one exponent bit per cycle.
// ============================================================================
module pfx_alu
    import pfx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_alu_rsp          o_rsp,
    output logic [DATA_W-1:0] o_result
);

    localparam int STEP_W = $clog2(DATA_W);

    t_alu_state        r_state;
    t_alu_state        n_state;
    logic [DATA_W-1:0] r_res;
    logic              r_dz;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;
    logic [STEP_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_base;
    logic [DATA_W-1:0] r_exp;

    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W:0]   w_shifted;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_mul_x;
    logic [DATA_W-1:0] w_mul_y;
    logic [DATA_W-1:0] w_mul_p;
    logic [DATA_W-1:0] w_sqr_p;
    logic [DATA_W-1:0] w_pow_special;

    assign w_mag_a   = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b   = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
    assign w_shifted = {r_rem, r_quo[DATA_W-1]};
    assign w_diff    = w_shifted - {1'b0, r_dvs};

    // One multiplier serves the product operator and the accumulator update.
    assign w_mul_x = (r_state == A_IDLE) ? i_a : r_acc;
    assign w_mul_y = (r_state == A_IDLE) ? i_b : r_base;
    assign w_mul_p = w_mul_x * w_mul_y;
    assign w_sqr_p = r_base * r_base;

    always_comb begin
        if (i_a == DATA_W'(1)) begin
            w_pow_special = DATA_W'(1);
        end else if (i_a == {DATA_W{1'b1}}) begin
            w_pow_special = i_b[0] ? {DATA_W{1'b1}} : DATA_W'(1);
        end else begin
            w_pow_special = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        OP_DIV:  n_state = (i_b == '0) ? A_DONE : A_DIV;
                        OP_POW:  n_state = i_b[DATA_W-1] ? A_DONE : A_POW;
                        default: n_state = A_DONE;
                    endcase
                end
            end
            A_DIV: begin
                if (r_cnt == STEP_W'(DATA_W - 1)) begin
                    n_state = A_SIGN;
                end
            end
            A_SIGN: n_state = A_DONE;
            A_POW: begin
                if (r_exp == '0) begin
                    n_state = A_DONE;
                end
            end
            A_DONE:  n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done     = (r_state == A_DONE);
        o_rsp.div_zero = r_dz;
        o_result       = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    r_dz <= 1'b0;
                    case (i_req.op)
                        OP_ADD: r_res <= i_a + i_b;
                        OP_SUB: r_res <= i_a - i_b;
                        OP_MUL: r_res <= w_mul_p;
                        OP_DIV: begin
                            r_dz  <= (i_b == '0);
                            r_rem <= '0;
                            r_quo <= w_mag_a;
                            r_dvs <= w_mag_b;
                            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                            r_cnt <= '0;
                            r_res <= '0;
                        end
                        OP_POW: begin
                            r_acc  <= DATA_W'(1);
                            r_base <= i_a;
                            r_exp  <= i_b;
                            r_res  <= w_pow_special;
                        end
                        default: r_res <= '0;
                    endcase
                end
            end
            A_DIV: begin
                r_quo <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
                r_rem <= w_diff[DATA_W] ? w_shifted[DATA_W-1:0] : w_diff[DATA_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            A_SIGN: begin
                r_res <= r_neg ? (~r_quo + 1'b1) : r_quo;
            end
            A_POW: begin
                if (r_exp == '0) begin
                    r_res <= r_acc;
                end else begin
                    if (r_exp[0]) begin
                        r_acc <= w_mul_p;
                    end
                    r_base <= w_sqr_p;
                    r_exp  <= r_exp >> 1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/postfix_expression_evaluator.sv
// ============================================================================
// postfix_expression_evaluator: reverse Polish expression evaluator
// A digit beat is pushed onto the stack when it is accepted. An operator beat
// reads the stack, then waits for the arithmetic unit: add, subtract and
// multiply in one step, division and power in the one-bit-per-cycle divider
// and power loop. The final beat then loads the result register, held back
// while an earlier result beat is still waiting.
// Synchronous active-low reset empties the stack and clears the error state.
// ============================================================================
module postfix_expression_evaluator
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = PFX_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    t_ctl_state        r_state;
    t_ctl_state        n_state;
    logic [CNT_W-1:0]  r_count;
    t_status           r_err;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_top;
    logic              r_last;
    t_alu_op           r_op;
    logic [DATA_W-1:0] r_out_data;
    t_status           r_out_status;

    logic              w_accept;
    logic              w_is_digit;
    logic              w_is_op;
    t_alu_op           w_op;
    logic              w_full;
    logic              w_slot_free;
    logic [CNT_W-1:0]  w_cnt_m2;
    logic [DATA_W-1:0] w_digit;

    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;

    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;
    logic [DATA_W-1:0] w_alu_result;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_is_digit  = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign w_full      = (r_count >= CNT_W'(STACK_DEPTH));
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_cnt_m2    = r_count - CNT_W'(2);
    assign w_digit     = {{(DATA_W - 4){1'b0}}, s_axis_tdata[3:0]};

    always_comb begin
        w_is_op = 1'b1;
        w_op    = OP_ADD;
        case (s_axis_tdata)
            CH_PLUS:  w_op = OP_ADD;
            CH_MINUS: w_op = OP_SUB;
            CH_STAR:  w_op = OP_MUL;
            CH_SLASH: w_op = OP_DIV;
            CH_CARET: w_op = OP_POW;
            default:  w_is_op = 1'b0;
        endcase
    end

    pfx_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pfx_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_rd_data),
        .i_b      (r_top),
        .o_rsp    (w_alu_rsp),
        .o_result (w_alu_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_err == ST_OK && w_is_op && r_count >= CNT_W'(2)) begin
                        n_state = S_FETCH;
                    end else if (s_axis_tlast) begin
                        n_state = S_END;
                    end
                end
            end
            S_FETCH: n_state = S_CALC;
            S_CALC: begin
                if (w_alu_rsp.done) begin
                    n_state = r_last ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        w_wr_en         = 1'b0;
        w_wr_addr       = r_count[ADDR_W-1:0];
        w_wr_data       = w_digit;
        w_rd_addr       = w_cnt_m2[ADDR_W-1:0];
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_op;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_accept && r_err == ST_OK && w_is_digit && !w_full) begin
                    w_wr_en = 1'b1;
                end
            end
            S_FETCH: begin
                w_alu_req.start = 1'b1;
            end
            S_CALC: begin
                w_wr_addr = w_cnt_m2[ADDR_W-1:0];
                w_wr_data = w_alu_result;
                if (w_alu_rsp.done && !w_alu_rsp.div_zero) begin
                    w_wr_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && r_err == ST_OK) begin
                        if (w_is_digit) begin
                            if (w_full) begin
                                r_err <= ST_OVERFLOW;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end else if (w_is_op) begin
                            if (r_count < CNT_W'(2)) begin
                                r_err <= ST_UNDERFLOW;
                            end
                        end else begin
                            r_err <= ST_INVALID;
                        end
                    end
                end
                S_CALC: begin
                    if (w_alu_rsp.done) begin
                        if (w_alu_rsp.div_zero) begin
                            r_err <= ST_DIV_ZERO;
                        end else begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                S_END: begin
                    if (w_slot_free) begin
                        r_count <= '0;
                        r_err   <= ST_OK;
                    end
                end
                default: begin
                end
            endcase
            if (r_state == S_END && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_last <= s_axis_tlast;
                    r_op   <= w_op;
                    if (r_err == ST_OK && w_is_digit && !w_full) begin
                        r_top <= w_digit;
                    end
                end
            end
            S_CALC: begin
                if (w_alu_rsp.done && !w_alu_rsp.div_zero) begin
                    r_top <= w_alu_result;
                end
            end
            S_END: begin
                if (w_slot_free) begin
                    if (r_err != ST_OK) begin
                        r_out_data   <= '0;
                        r_out_status <= r_err;
                    end else if (r_count == '0) begin
                        r_out_data   <= '0;
                        r_out_status <= ST_UNDERFLOW;
                    end else begin
                        r_out_data   <= r_top;
                        r_out_status <= ST_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("Operand count exceeds the stack depth.");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && w_slot_free) |=> (r_count == '0 && r_err == ST_OK))
        else $error("Stack or error state not cleared after the final beat.");

    a_alu_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == S_CALC))
        else $error("Arithmetic unit finished outside the calculation state.");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_END))
        else $error("Result beat raised without a final input beat.");

endmodule

### tb/postfix_expression_evaluator_test.sv
// ============================================================================
// postfix_expression_evaluator_test: self-checking bench for the evaluator
// Streams postfix expressions into the block, one character per beat, and
// predicts each final value and status from an independent stack model.
// Directed cases cover every operator and every error; random expressions,
// mostly well formed, reach deep stacks, wrapped powers and corrupted input.
// ============================================================================
`timescale 1ns / 100ps

module postfix_expression_evaluator_test;
    import pfx_pkg::*;

    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_outcome;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] symbol
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [31:0] result_value
    logic [2:0]  m_axis_tuser;            // [2:0] status

    t_outcome    pending_outcomes[$];
    logic [31:0] eval_stack [PFX_STACK_DEPTH];
    int          eval_depth = 0;
    t_status     eval_error = ST_OK;
    logic [7:0]  expr_syms[$];
    int          gen_depth;
    int          symbols_sent = 0;
    int          fail_count = 0;
    bit          idle_on = 1'b1;
    int unsigned rx_hold = 0;

    postfix_expression_evaluator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        acc = 32'd1;
        if (expo[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (expo != 32'd0) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] truncated_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        q  = ma / mb;
        if (a[31] ^ b[31]) q = 32'd0 - q;
        return q;
    endfunction

    task automatic track_symbol(input logic [7:0] sym, input logic lst);
        t_outcome    res;
        logic [31:0] a, b, r;
        bit          ok;
        if (eval_error == ST_OK) begin
            if (sym >= CH_ZERO && sym <= CH_NINE) begin
                if (eval_depth >= PFX_STACK_DEPTH) begin
                    eval_error = ST_OVERFLOW;
                end else begin
                    eval_stack[eval_depth] = {24'd0, sym - CH_ZERO};
                    eval_depth++;
                end
            end else begin
                case (sym)
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
                        if (eval_depth < 2) begin
                            eval_error = ST_UNDERFLOW;
                        end else begin
                            b  = eval_stack[eval_depth - 1];
                            a  = eval_stack[eval_depth - 2];
                            ok = 1'b1;
                            r  = 32'd0;
                            case (sym)
                                CH_PLUS:  r = a + b;
                                CH_MINUS: r = a - b;
                                CH_STAR:  r = a * b;
                                CH_CARET: r = wrapped_power(a, b);
                                default: begin
                                    if (b == 32'd0) begin
                                        eval_error = ST_DIV_ZERO;
                                        ok = 1'b0;
                                    end else begin
                                        r = truncated_quotient(a, b);
                                    end
                                end
                            endcase
                            if (ok) begin
                                eval_depth--;
                                eval_stack[eval_depth - 1] = r;
                            end
                        end
                    end
                    default: eval_error = ST_INVALID;
                endcase
            end
        end
        if (lst) begin
            res.value = 32'd0;
            if (eval_error == ST_OK) begin
                if (eval_depth == 0) eval_error = ST_UNDERFLOW;
                else res.value = eval_stack[eval_depth - 1];
            end
            res.status = eval_error;
            pending_outcomes.push_back(res);
            eval_depth = 0;
            eval_error = ST_OK;
        end
    endtask

    task automatic send_symbol(input logic [7:0] sym, input logic lst);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_symbol(sym, lst);
        symbols_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
    endtask

    task automatic send_expression();
        for (int i = 0; i < expr_syms.size(); i++)
            send_symbol(expr_syms[i], i == expr_syms.size() - 1);
    endtask

    function automatic logic [7:0] any_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_operator();
        expr_syms.push_back(any_operator());
        gen_depth--;
    endtask

    task automatic add_leaf();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind >= 85 && gen_depth <= PFX_STACK_DEPTH - 5) begin
            // Two to the power 31 gives the most negative value.
            expr_syms.push_back(CH_ZERO + 8'd2);
            repeat (3) expr_syms.push_back(CH_NINE);
            expr_syms.push_back(CH_ZERO + 8'd4);
            repeat (3) expr_syms.push_back(CH_PLUS);
            expr_syms.push_back(CH_CARET);
        end else if (kind >= 60 && gen_depth <= PFX_STACK_DEPTH - 2) begin
            if (kind < 78) begin
                expr_syms.push_back(CH_ZERO);
                expr_syms.push_back(any_digit());
                expr_syms.push_back(CH_MINUS);
            end else begin
                expr_syms.push_back(CH_ZERO + 8'($urandom_range(7, 9)));
                expr_syms.push_back(CH_NINE);
                expr_syms.push_back(CH_CARET);
            end
        end else begin
            expr_syms.push_back(any_digit());
        end
        gen_depth++;
    endtask

    task automatic build_well_formed(input int unsigned target);
        expr_syms.delete();
        gen_depth = 0;
        while (expr_syms.size() < target || gen_depth == 0) begin
            if (gen_depth >= 2 &&
                (gen_depth >= PFX_STACK_DEPTH || $urandom_range(0, 99) < 45))
                add_operator();
            else
                add_leaf();
        end
        while (gen_depth > 1 && $urandom_range(0, 5) != 0) add_operator();
    endtask

    task automatic test_single_operands();
        send_text("5");
        send_text("9");
        send_text("0");
        send_text("123");
    endtask

    task automatic test_operators();
        send_text("34+");
        send_text("34-");
        send_text("34*");
        send_text("93/");
        send_text("23^");
        send_text("00^");
        send_text("201-^");
    endtask

    task automatic test_error_cases();
        send_text("+");
        send_text("1+2");
        send_text("50/");
        send_symbol(CH_ZERO + 8'd5, 1'b0);
        send_symbol(CH_LOWER_A, 1'b1);
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
    endtask

    task automatic test_stack_limits();
        int unsigned n;
        // A full stack, then a digit on the final beat.
        expr_syms.delete();
        repeat (PFX_STACK_DEPTH + 1) expr_syms.push_back(any_digit());
        send_expression();
        // The most negative value divided by minus one.
        send_text("29994+++^01-/");
        expr_syms.delete();
        repeat (PFX_STACK_DEPTH) expr_syms.push_back(any_digit());
        n = $urandom_range(1, PFX_STACK_DEPTH - 1);
        repeat (n) expr_syms.push_back(any_operator());
        send_expression();
    endtask

    task automatic random_expression();
        int unsigned pick, pos, n;
        pick = $urandom_range(0, 99);
        if (pick < 92 && pick >= 87) begin
            expr_syms.delete();
            n = $urandom_range(PFX_STACK_DEPTH - 1, PFX_STACK_DEPTH + 4);
            repeat (n) expr_syms.push_back(any_digit());
            n = $urandom_range(0, 6);
            repeat (n) expr_syms.push_back(any_operator());
        end else if (pick >= 92) begin
            expr_syms.delete();
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0)
                    expr_syms.push_back(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 1) == 0)
                    expr_syms.push_back(any_digit());
                else
                    expr_syms.push_back(any_operator());
            end
        end else begin
            if ($urandom_range(0, 9) == 0) build_well_formed($urandom_range(13, 30));
            else build_well_formed($urandom_range(1, 12));
            if (pick >= 75 && pick < 82) begin
                pos = $urandom_range(0, expr_syms.size() - 1);
                expr_syms[pos] = 8'($urandom_range(0, 255));
            end else if (pick >= 82) begin
                if ($urandom_range(0, 1) == 0) expr_syms.push_front(any_operator());
                else repeat (2) expr_syms.push_back(any_operator());
            end
        end
        send_expression();
    endtask

    task automatic test_random_expressions(input int stop_at);
        while (symbols_sent < stop_at) begin
            idle_on = ($urandom_range(0, 2) != 0);
            random_expression();
        end
    endtask

    task automatic test_without_idling(input int stop_at);
        idle_on = 1'b0;
        while (symbols_sent < stop_at) random_expression();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold       <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result beat: result_value %0d, status %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata !== want.value) begin
                    $error("result_value: expected %0d, got %0d",
                           $signed(want.value), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_operands();
        test_operators();
        test_error_cases();
        test_stack_limits();
        test_random_expressions(1150);
        test_without_idling(1300);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $error("timeout with %0d results outstanding", pending_outcomes.size());
        $display("FAILURE");
        $finish;
    end

endmodule
